FILE: hdl/e2r_pkg.sv
// Package for the Euler-angle to rotation-matrix block: constants, types and helpers.
package e2r_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ANG_W = 16;
  localparam int OUT_W = 16;
  localparam int CW = 34;   // CORDIC x/y width (Q2.30 plus growth and sign)
  localparam int ZW = 34;   // residual angle width, 2^32 counts per turn
  localparam int Q14_W = 16;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Q14_W-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;
  typedef logic signed [Q14_W-1:0] q14_t;

  // One CORDIC lane state for a single angle.
  typedef struct packed {
    cw_t x;
    cw_t y;
    zw_t z;
    logic [1:0] quad;
  } lane_t;

  function automatic zw_t atan_val(input int i);
    case (i)
      0: atan_val = 34'sd536870912;
      1: atan_val = 34'sd316933406;
      2: atan_val = 34'sd167458907;
      3: atan_val = 34'sd85004756;
      4: atan_val = 34'sd42667331;
      5: atan_val = 34'sd21354465;
      6: atan_val = 34'sd10679838;
      7: atan_val = 34'sd5340245;
      8: atan_val = 34'sd2670163;
      9: atan_val = 34'sd1335087;
      10: atan_val = 34'sd667544;
      11: atan_val = 34'sd333772;
      12: atan_val = 34'sd166886;
      13: atan_val = 34'sd83443;
      14: atan_val = 34'sd41722;
      15: atan_val = 34'sd20861;
      16: atan_val = 34'sd10430;
      17: atan_val = 34'sd5215;
      18: atan_val = 34'sd2608;
      19: atan_val = 34'sd1304;
      20: atan_val = 34'sd652;
      21: atan_val = 34'sd326;
      22: atan_val = 34'sd163;
      23: atan_val = 34'sd81;
      default: atan_val = '0;
    endcase
  endfunction

  // Split an angle into quadrant and residual; load the CORDIC start values.
  function automatic lane_t lane_init(input logic [ANG_W-1:0] a);
    lane_t l;
    logic [ANG_W-1:0] s;
    logic [ANG_W-1:0] r;
    s = a + 16'd8192;
    l.quad = s[15:14];
    r = a - {l.quad, 14'd0};
    l.x = GAIN_Q30;
    l.y = '0;
    l.z = {{(ZW-ANG_W-16){r[ANG_W-1]}}, r, 16'd0};
    return l;
  endfunction

  // One CORDIC micro-rotation; >>> rounds toward minus infinity.
  function automatic lane_t lane_step(input lane_t l, input int i);
    lane_t o;
    cw_t dx;
    cw_t dy;
    dx = l.y >>> i;
    dy = l.x >>> i;
    o.quad = l.quad;
    if (!l.z[ZW-1]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - atan_val(i);
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + atan_val(i);
    end
    return o;
  endfunction

  // Round half away from zero by a right shift of SH, then clamp to +-1.0 in Q1.14.
  function automatic q14_t rnd_sat(input logic signed [63:0] v, input int sh);
    logic signed [63:0] half;
    logic signed [63:0] m;
    logic signed [63:0] r;
    half = 64'sd1 <<< (sh - 1);
    if (!v[63]) begin
      r = (v + half) >>> sh;
    end else begin
      m = -v;
      r = -((m + half) >>> sh);
    end
    if (r > 64'sd16384) rnd_sat = ONE_Q14;
    else if (r < -64'sd16384) rnd_sat = -ONE_Q14;
    else rnd_sat = r[Q14_W-1:0];
  endfunction

endpackage

FILE: hdl/e2r_sincos.sv
// Pipelined CORDIC producing Q1.14 sine and cosine of three angles in parallel.
module e2r_sincos #(
  parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [e2r_pkg::ANG_W-1:0] ang [3],
  output logic out_valid,
  output e2r_pkg::q14_t sin_o [3],
  output e2r_pkg::q14_t cos_o [3]
);
  localparam int NS = (CORDIC_STAGES > e2r_pkg::ATAN_ENTRIES) ?
                      e2r_pkg::ATAN_ENTRIES : CORDIC_STAGES;

  e2r_pkg::lane_t lane [NS+1][3];
  logic vld [NS+1];

  // Stage 0 registers the quadrant split.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
    if (en) begin
      for (int k = 0; k < 3; k++) lane[0][k] <= e2r_pkg::lane_init(ang[k]);
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (en) vld[g+1] <= vld[g];
      if (en) begin
        for (int k = 0; k < 3; k++) lane[g+1][k] <= e2r_pkg::lane_step(lane[g][k], g);
      end
    end
  end

  // Quadrant rotation and rounding to Q1.14.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[NS];
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        case (lane[NS][k].quad)
          2'd0: begin
            cos_o[k] <= e2r_pkg::rnd_sat(64'(lane[NS][k].x), 16);
            sin_o[k] <= e2r_pkg::rnd_sat(64'(lane[NS][k].y), 16);
          end
          2'd1: begin
            cos_o[k] <= e2r_pkg::rnd_sat(-64'(lane[NS][k].y), 16);
            sin_o[k] <= e2r_pkg::rnd_sat(64'(lane[NS][k].x), 16);
          end
          2'd2: begin
            cos_o[k] <= e2r_pkg::rnd_sat(-64'(lane[NS][k].x), 16);
            sin_o[k] <= e2r_pkg::rnd_sat(-64'(lane[NS][k].y), 16);
          end
          default: begin
            cos_o[k] <= e2r_pkg::rnd_sat(64'(lane[NS][k].y), 16);
            sin_o[k] <= e2r_pkg::rnd_sat(-64'(lane[NS][k].x), 16);
          end
        endcase
      end
    end
  end
endmodule

FILE: hdl/euler_to_rotation_matrix.sv
// Top level: Euler angles (Z-Y-X) to a 3x3 Q1.14 rotation matrix, fully pipelined.
//
// Usage: present yaw_angle, pitch_angle and roll_angle (binary angles, 65536
// counts per turn) with in_valid; an item is accepted when in_valid and
// in_ready are both high. The nine matrix entries appear on m00..m22 with
// out_valid and are taken when out_ready is high.
// Throughput is one item per clock cycle unless the receiver stalls. The path
// from acceptance to out_valid (with CORDIC_STAGES capped at 24) is one
// quadrant-split stage, one stage per CORDIC iteration, one rounding
// stage, then three product stages for the matrix terms.
// The whole pipeline advances together. When the receiver stalls with a
// result waiting, in_ready drops and every stage holds its contents, so no
// item is lost or repeated; when the output stage is empty or being taken,
// in_ready stays high even though earlier items are still in flight.
// Reset clears all valid bits; data registers are not reset.
module euler_to_rotation_matrix #(
  parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);
  // Global enable: the pipeline moves whenever the output slot is free.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic [e2r_pkg::ANG_W-1:0] ang [3];
  e2r_pkg::q14_t sn [3];
  e2r_pkg::q14_t cs [3];
  logic sc_valid;

  assign ang[0] = yaw_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = roll_angle;

  e2r_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sincos (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .ang(ang), .out_valid(sc_valid), .sin_o(sn), .cos_o(cs)
  );

  // Stage A: two-factor products (Q2.28) plus the values still needed.
  logic va;
  logic signed [31:0] cycp, sycp, cpsr, cpcr, cysp, sysp, sycr, sysr, cycr, cysr;
  e2r_pkg::q14_t sr_a, cr_a, sp_a;
  // Stage B: three-factor terms (Q3.42) and aligned two-factor terms.
  logic vb;
  logic signed [47:0] t01, t02, t11, t12, u01, u02, u11, u12;
  logic signed [31:0] cycp_b, sycp_b, cpsr_b, cpcr_b;
  e2r_pkg::q14_t sp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= sc_valid;
      vb <= va;
      out_valid <= vb;
    end
    if (en) begin
      cycp <= cs[0] * cs[1];
      sycp <= sn[0] * cs[1];
      cpsr <= cs[1] * sn[2];
      cpcr <= cs[1] * cs[2];
      cysp <= cs[0] * sn[1];
      sysp <= sn[0] * sn[1];
      sycr <= sn[0] * cs[2];
      sysr <= sn[0] * sn[2];
      cycr <= cs[0] * cs[2];
      cysr <= cs[0] * sn[2];
      sr_a <= sn[2];
      cr_a <= cs[2];
      sp_a <= sn[1];

      t01 <= cysp * sr_a;
      t02 <= cysp * cr_a;
      t11 <= sysp * sr_a;
      t12 <= sysp * cr_a;
      u01 <= 48'(sycr) <<< 14;
      u02 <= 48'(sysr) <<< 14;
      u11 <= 48'(cycr) <<< 14;
      u12 <= 48'(cysr) <<< 14;
      cycp_b <= cycp;
      sycp_b <= sycp;
      cpsr_b <= cpsr;
      cpcr_b <= cpcr;
      sp_b <= sp_a;

      m00 <= e2r_pkg::rnd_sat(64'(cycp_b), 14);
      m10 <= e2r_pkg::rnd_sat(64'(sycp_b), 14);
      m21 <= e2r_pkg::rnd_sat(64'(cpsr_b), 14);
      m22 <= e2r_pkg::rnd_sat(64'(cpcr_b), 14);
      m20 <= sp_b;
      m01 <= e2r_pkg::rnd_sat(-64'(t01) - 64'(u01), 28);
      m02 <= e2r_pkg::rnd_sat(-64'(t02) + 64'(u02), 28);
      m11 <= e2r_pkg::rnd_sat(-64'(t11) + 64'(u11), 28);
      m12 <= e2r_pkg::rnd_sat(-64'(t12) - 64'(u12), 28);
    end
  end
endmodule

FILE: hdl/e2r_checker.sv
// Port-level checker for the Euler-angle to rotation-matrix block, with its bind.
module e2r_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] m00,
  input logic signed [15:0] m20,
  input logic signed [15:0] m22
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m22))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> m20 <= 16'sd16384 && m20 >= -16'sd16384)
    else $error("entry out of range");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind euler_to_rotation_matrix e2r_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .m00(m00), .m20(m20), .m22(m22)
);
